// ----- hdl/simpson_integrate_poly_defines.svh -----
// ----------------------------------------------------------------------------
// Simpson integrator assertion macros
// Concurrent assertion wrappers shared by the integrator RTL.
// ----------------------------------------------------------------------------
`ifndef SIMPSON_INTEGRATE_POLY_DEFINES_SVH
`define SIMPSON_INTEGRATE_POLY_DEFINES_SVH
`ifndef ASSERT_OFF
`define SIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SIP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator package
// Shared constants, command/status types and the saturating weighted add.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int DATA_W            = 64;
  localparam int CNT_W             = 13;
  localparam int BOUND_W           = 24;
  localparam int SH_W              = 7;
  localparam int MAX_INTERVALS_DEF = 4096;
  localparam int FRAC_BITS_DEF     = 16;

  localparam logic [DATA_W-1:0] PI_Q32  = 64'd13493037705;
  localparam logic [DATA_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  // (2^65 + 1) / 3: x / 3 == (x * RECIP3) >> 65 for any 64-bit x
  localparam logic [DATA_W-1:0] RECIP3  = 64'hAAAA_AAAA_AAAA_AAAB;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SMALL = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  typedef enum logic [2:0] {
    MSEL_Q  = 3'd0,
    MSEL_R  = 3'd1,
    MSEL_F  = 3'd2,
    MSEL_P3 = 3'd3,
    MSEL_P1 = 3'd4,
    MSEL_D3 = 3'd5
  } msel_t;

  typedef struct packed {
    logic  load;
    logic  div_h;
    logic  set_h;
    logic  mul_go;
    msel_t mul_sel;
    logic  cap_q;
    logic  cap_r;
    logic  cap_f;
    logic  s3x3;
    logic  cap_p3;
    logic  cap_p1;
    logic  cap_d3;
    logic  publish;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_odd;
    logic n_is3;
    logic last_pt;
    logic mul_done;
    logic div_done;
    logic out_free;
  } sts_t;

  // {saturated, min(acc + w * f, 2^64 - 1)}
  function automatic logic [DATA_W:0] wadd(logic [DATA_W-1:0] acc, logic [DATA_W-1:0] f,
                                           logic [2:0] w);
    logic [DATA_W+2:0] sum;
    sum = {3'b000, acc} + ({3'b000, f} * {{DATA_W{1'b0}}, w});
    if (sum[DATA_W+2:DATA_W] != 3'd0) begin
      return {1'b1, {DATA_W{1'b1}}};
    end
    return {1'b0, sum[DATA_W-1:0]};
  endfunction

endpackage

// ----- hdl/sip_mul.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator multiplier
// 64x64 product from four 32x32 partial products, then shift and overflow check.
// ----------------------------------------------------------------------------
module sip_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [sip_pkg::DATA_W-1:0]   op_a,
  input  logic [sip_pkg::DATA_W-1:0]   op_b,
  input  logic [sip_pkg::SH_W-1:0]     sh,
  output logic                         done,
  output logic [sip_pkg::DATA_W-1:0]   res,
  output logic                         sat
);

  logic [63:0]  a_r, b_r;
  logic [sip_pkg::SH_W-1:0] sh_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r;
  logic [63:0]  res_r;
  logic         sat_r;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] part;
  logic [127:0] shifted;
  logic [127:0] upper;

  always_comb begin
    pa = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    pb = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp = pa * pb;
    case (cnt_r[1:0])
      2'd0:    part = {64'd0, pp};
      2'd3:    part = {pp, 64'd0};
      default: part = {32'd0, pp, 32'd0};
    endcase
    shifted = acc_r >> sh_r;
    upper   = acc_r >> ({1'b0, sh_r} + 8'd64);
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (go) begin
      a_r    <= op_a;
      b_r    <= op_b;
      sh_r   <= sh;
      acc_r  <= '0;
      cnt_r  <= 3'd0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (!cnt_r[2]) begin
        acc_r <= acc_r + part;
        cnt_r <= cnt_r + 3'd1;
      end else begin
        res_r  <= shifted[63:0];
        sat_r  <= (upper != 128'd0);
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

// ----- hdl/sip_div.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator divider
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sip_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [sip_pkg::DATA_W-1:0]  dividend,
  input  logic [sip_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [sip_pkg::DATA_W-1:0]  quotient
);

  localparam int DW = sip_pkg::DATA_W;
  localparam int NW = sip_pkg::CNT_W;

  logic [DW-1:0]    q_r;
  logic [NW-1:0]    rem_r, d_r;
  logic [6:0]       cnt_r;
  logic             busy_r, done_r;
  logic [NW:0]      rem_sh;
  logic             take;

  always_comb begin
    rem_sh = {rem_r, q_r[DW-1]};
    take   = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (go) begin
      q_r    <= dividend;
      d_r    <= divisor;
      rem_r  <= '0;
      cnt_r  <= 7'd0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], take};
      rem_r <= take ? NW'(rem_sh - {1'b0, d_r}) : NW'(rem_sh);
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hdl/sip_ctrl.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator controller
// Sequences step division, per-point integrand, final products and output.
// ----------------------------------------------------------------------------
`include "simpson_integrate_poly_defines.svh"

module sip_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output sip_pkg::cmd_t cmd,
  input  sip_pkg::sts_t sts
);

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_CHECK = 16'h0002,
    ST_DIVH  = 16'h0004,
    ST_PT    = 16'h0008,
    ST_WQ    = 16'h0010,
    ST_GR    = 16'h0020,
    ST_WR    = 16'h0040,
    ST_GF    = 16'h0080,
    ST_WF    = 16'h0100,
    ST_POST  = 16'h0200,
    ST_GP3   = 16'h0400,
    ST_WP3   = 16'h0800,
    ST_GP1   = 16'h1000,
    ST_WP1   = 16'h2000,
    ST_WD3   = 16'h4000,
    ST_FIN   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.n_small) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_h = 1'b1;
          state_nxt = ST_DIVH;
        end
      end
      ST_DIVH: begin
        if (sts.div_done) begin
          cmd.set_h = 1'b1;
          state_nxt = ST_PT;
        end
      end
      ST_PT: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = sip_pkg::MSEL_Q;
        state_nxt   = ST_WQ;
      end
      ST_WQ: begin
        if (sts.mul_done) begin
          cmd.cap_q = 1'b1;
          state_nxt = ST_GR;
        end
      end
      ST_GR: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = sip_pkg::MSEL_R;
        state_nxt   = ST_WR;
      end
      ST_WR: begin
        if (sts.mul_done) begin
          cmd.cap_r = 1'b1;
          state_nxt = ST_GF;
        end
      end
      ST_GF: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = sip_pkg::MSEL_F;
        state_nxt   = ST_WF;
      end
      ST_WF: begin
        if (sts.mul_done) begin
          cmd.cap_f = 1'b1;
          state_nxt = sts.last_pt ? ST_POST : ST_PT;
        end
      end
      ST_POST: begin
        if (sts.n_odd) begin
          cmd.s3x3  = 1'b1;
          state_nxt = ST_GP3;
        end else begin
          state_nxt = ST_GP1;
        end
      end
      ST_GP3: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = sip_pkg::MSEL_P3;
        state_nxt   = ST_WP3;
      end
      ST_WP3: begin
        if (sts.mul_done) begin
          cmd.cap_p3 = 1'b1;
          state_nxt  = sts.n_is3 ? ST_FIN : ST_GP1;
        end
      end
      ST_GP1: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = sip_pkg::MSEL_P1;
        state_nxt   = ST_WP1;
      end
      ST_WP1: begin
        if (sts.mul_done) begin
          cmd.cap_p1  = 1'b1;
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = sip_pkg::MSEL_D3;
          state_nxt   = ST_WD3;
        end
      end
      ST_WD3: begin
        if (sts.mul_done) begin
          cmd.cap_d3 = 1'b1;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SIP_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> state_r == ST_IDLE, "not idle after reset")
  `SIP_ASSERT(a_pub_free, clk, rst_n, cmd.publish |-> sts.out_free, "publish into busy output")
  `SIP_ASSERT(a_load_acc, clk, rst_n, cmd.load |-> (in_valid && !in_stall), "load without word")

endmodule

// ----- hdl/sip_dpath.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator datapath
// Step, sample point, integrand chain, weighted sums and saturated result.
// ----------------------------------------------------------------------------
`include "simpson_integrate_poly_defines.svh"

module sip_dpath #(
  parameter int MAX_INTERVALS = sip_pkg::MAX_INTERVALS_DEF,
  parameter int FRAC_BITS     = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [sip_pkg::BOUND_W-1:0]  in_lower_bound,
  input  logic signed [sip_pkg::BOUND_W-1:0]  in_upper_bound,
  input  logic [sip_pkg::CNT_W-1:0]           in_interval_count,
  input  sip_pkg::cmd_t                       cmd,
  output sip_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sip_pkg::DATA_W-1:0]   out_integral,
  output logic [1:0]                          out_status
);

  localparam int DW       = sip_pkg::DATA_W;
  localparam int NW       = sip_pkg::CNT_W;
  localparam int SCALE_SH = 24 - FRAC_BITS;

  logic signed [sip_pkg::BOUND_W-1:0] a_r, b_r;
  logic [NW-1:0]          n_r, idx_r;
  logic                   small_r;
  logic signed [DW-1:0]   h_r, x_r;
  logic [DW-1:0]          habs_r, t_r, r_r, s_r, s3_r, mag_r;
  logic                   neg_r, sat_r;
  logic                   out_valid_r;
  logic signed [DW-1:0]   out_integral_r;
  logic [1:0]             out_status_r;

  logic signed [DW-1:0]   a64, b64, diff, a24;
  logic [DW-1:0]          dmag, div_h_in, xabs;
  logic [NW-1:0]          n_clamp, jj;
  logic                   mul_go, mul_done, mul_sat, div_go, div_done;
  logic [DW-1:0]          mul_a, mul_b, mul_res, div_in, div_quo;
  logic [sip_pkg::SH_W-1:0] mul_sh;
  logic [NW-1:0]          div_d;
  logic [DW:0]            t_sum, d3_sum, s_new, s3_new, s3x3_new;
  logic [2:0]             w, w3;
  logic                   use_s, use_s3;
  logic [DW-1:0]          lim, mag_f;
  logic                   sat_f;

  always_comb begin
    n_clamp  = (32'(in_interval_count) > MAX_INTERVALS) ? NW'(MAX_INTERVALS)
                                                         : in_interval_count;
    a64      = DW'(a_r);
    b64      = DW'(b_r);
    diff     = b64 - a64;
    dmag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
    div_h_in = dmag << SCALE_SH;
    a24      = a64 <<< SCALE_SH;
    xabs     = x_r[DW-1] ? DW'(-x_r) : DW'(x_r);

    mul_go = cmd.mul_go;
    case (cmd.mul_sel)
      sip_pkg::MSEL_Q:  begin mul_a = xabs;  mul_b = xabs;           mul_sh = 7'd18; end
      sip_pkg::MSEL_R:  begin mul_a = t_r;   mul_b = t_r;            mul_sh = 7'd48; end
      sip_pkg::MSEL_F:  begin mul_a = r_r;   mul_b = sip_pkg::PI_Q32; mul_sh = 7'd32; end
      sip_pkg::MSEL_P3: begin mul_a = s3_r;  mul_b = habs_r;         mul_sh = 7'd27; end
      sip_pkg::MSEL_D3: begin mul_a = mul_res; mul_b = sip_pkg::RECIP3; mul_sh = 7'd65; end
      default:          begin mul_a = s_r;   mul_b = habs_r;         mul_sh = 7'd24; end
    endcase

    div_go = cmd.div_h;
    div_in = div_h_in;
    div_d  = n_r;

    t_sum  = {1'b0, sip_pkg::ONE_Q32} + {1'b0, mul_res};
    d3_sum = {1'b0, mag_r} + {1'b0, mul_res};

    jj     = n_r[0] ? NW'(idx_r - NW'(3)) : idx_r;
    use_s3 = n_r[0] && (idx_r < NW'(4));
    use_s  = !n_r[0] || ((idx_r >= NW'(3)) && (n_r != NW'(3)));
    w3     = ((idx_r == '0) || (idx_r == NW'(3))) ? 3'd1 : 3'd3;
    w      = ((jj == '0) || (idx_r == n_r)) ? 3'd1 : (jj[0] ? 3'd4 : 3'd2);
    s_new    = sip_pkg::wadd(s_r, mul_res, w);
    s3_new   = sip_pkg::wadd(s3_r, mul_res, w3);
    s3x3_new = sip_pkg::wadd('0, s3_r, 3'd3);

    lim   = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    sat_f = sat_r || (mag_r > lim);
    mag_f = sat_f ? lim : mag_r;

    sts.n_small  = small_r;
    sts.n_odd    = n_r[0];
    sts.n_is3    = (n_r == NW'(3));
    sts.last_pt  = (idx_r == n_r);
    sts.mul_done = mul_done;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  sip_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  sip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_in),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= in_lower_bound;
      b_r     <= in_upper_bound;
      n_r     <= n_clamp;
      small_r <= (in_interval_count < NW'(2));
      s_r     <= '0;
      s3_r    <= '0;
      mag_r   <= '0;
      sat_r   <= 1'b0;
      neg_r   <= 1'b0;
    end
    if (cmd.set_h) begin
      h_r    <= diff[DW-1] ? DW'(-div_quo) : DW'(div_quo);
      habs_r <= div_quo;
      neg_r  <= diff[DW-1] && (div_quo != '0);
      x_r    <= a24;
      idx_r  <= '0;
    end
    if (cmd.cap_q) begin
      t_r   <= t_sum[DW] ? {DW{1'b1}} : t_sum[DW-1:0];
      sat_r <= sat_r | mul_sat | t_sum[DW];
    end
    if (cmd.cap_r) begin
      r_r   <= mul_res;
      sat_r <= sat_r | mul_sat;
    end
    if (cmd.cap_f) begin
      if (use_s) begin
        s_r <= s_new[DW-1:0];
      end
      if (use_s3) begin
        s3_r <= s3_new[DW-1:0];
      end
      sat_r <= sat_r | mul_sat | (use_s & s_new[DW]) | (use_s3 & s3_new[DW]);
      idx_r <= idx_r + NW'(1);
      x_r   <= x_r + h_r;
    end
    if (cmd.s3x3) begin
      s3_r  <= s3x3_new[DW-1:0];
      sat_r <= sat_r | s3x3_new[DW];
    end
    if (cmd.cap_p3) begin
      mag_r <= mul_res;
      sat_r <= sat_r | mul_sat;
    end
    if (cmd.cap_p1) begin
      sat_r <= sat_r | mul_sat;
    end
    if (cmd.cap_d3) begin
      mag_r <= d3_sum[DW] ? {DW{1'b1}} : d3_sum[DW-1:0];
      sat_r <= sat_r | d3_sum[DW];
    end
    if (cmd.publish) begin
      if (small_r) begin
        out_integral_r <= '0;
        out_status_r   <= sip_pkg::STAT_SMALL;
      end else begin
        out_integral_r <= neg_r ? DW'(-mag_f) : DW'(mag_f);
        out_status_r   <= sat_f ? sip_pkg::STAT_SAT : sip_pkg::STAT_OK;
      end
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_integral = out_integral_r;
  assign out_status   = out_status_r;

  `SIP_ASSERT(a_pub_valid, clk, rst_n, cmd.publish |=> out_valid_r, "published word not valid")
  `SIP_ASSERT(a_small_zero, clk, rst_n, (out_valid_r && out_status_r == sip_pkg::STAT_SMALL) |-> (out_integral_r == '0), "short count with nonzero integral")
  `SIP_ASSERT(a_sat_ext, clk, rst_n, (out_valid_r && out_status_r == sip_pkg::STAT_SAT) |-> (out_integral_r == {1'b0, {(DW-1){1'b1}}} || out_integral_r == {1'b1, {(DW-1){1'b0}}}), "saturated word not at extreme")

endmodule

// ----- hdl/simpson_integrate_poly.sv -----
// ----------------------------------------------------------------------------
// Simpson integrator top level
// Integral of pi*(1+(x/2)^2)^2 over [a,b] by composite Simpson rules.
// ----------------------------------------------------------------------------
// Input word: lower/upper bound (Q8.16) and interval count, taken when
// in_valid is high and in_stall low. in_stall is high while a word is at work.
// Output word: integral (Q48.16, saturated) and status, held in an output
// register until the receiver takes it (out_valid high, out_stall low).
// A held result does not block acceptance of the next input word; it only
// delays the end of the next computation until the register frees up.
// Steps: a serial divide for the step size, three passes through the
// multiplier per sample point, then the closing products and the divide
// by three, done as a multiply by a reciprocal. A count below two skips
// the computation and goes straight to the output. One word at a time.
// Reset (synchronous, active low) returns the controller to idle and drops
// out_valid; a word in progress is lost.
// ----------------------------------------------------------------------------
module simpson_integrate_poly #(
  parameter int MAX_INTERVALS = sip_pkg::MAX_INTERVALS_DEF,
  parameter int FRAC_BITS     = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sip_pkg::BOUND_W-1:0]  in_lower_bound,
  input  logic signed [sip_pkg::BOUND_W-1:0]  in_upper_bound,
  input  logic [sip_pkg::CNT_W-1:0]           in_interval_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sip_pkg::DATA_W-1:0]   out_integral,
  output logic [1:0]                          out_status
);

  sip_pkg::cmd_t cmd;
  sip_pkg::sts_t sts;

  sip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  sip_dpath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_lower_bound    (in_lower_bound),
    .in_upper_bound    (in_upper_bound),
    .in_interval_count (in_interval_count),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_integral      (out_integral),
    .out_status        (out_status)
  );

endmodule
